// File: hdl/cprm_pkg.sv
// Shared constants, command codes, state type and control structs for the tachometer.
package cprm_pkg;

    localparam int AVG_DEPTH      = 200;
    localparam int OVERFLOW_LIMIT = 50;
    localparam int RING_AW        = $clog2(AVG_DEPTH);
    localparam int CNT_W          = $clog2(AVG_DEPTH + 1);
    localparam int RES_W          = 34;
    localparam int SUM_W          = 42;
    localparam int PER_W          = 22;
    localparam int OVF_W          = 6;
    localparam int CAP_W          = 16;
    localparam int PPR_W          = 16;
    localparam int NUM_W          = 42;
    localparam int DEN_W          = PER_W + PPR_W;

    localparam logic [NUM_W-1:0] RPM_NUM  = NUM_W'(64'd15360000000);
    localparam logic [NUM_W-1:0] FREQ_NUM = NUM_W'(64'd256000000);

    localparam logic [2:0] CMD_OVERFLOW  = 3'd0;
    localparam logic [2:0] CMD_CAPTURE   = 3'd1;
    localparam logic [2:0] CMD_READ_RPM  = 3'd2;
    localparam logic [2:0] CMD_READ_AVG  = 3'd3;
    localparam logic [2:0] CMD_READ_FREQ = 3'd4;
    localparam logic [2:0] CMD_CLEAR_AVG = 3'd5;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_PPR    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV1,
        ST_WAIT1,
        ST_RING,
        ST_DIV2,
        ST_WAIT2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_item;
        logic clear_result;
        logic exec_event;
        logic mul_en;
        logic div_start;
        logic div_sel_avg;
        logic take_quot;
        logic ring_upd;
        logic avg_result;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       rpm_ok;
        logic       freq_ok;
        logic       div_done;
        logic       out_free;
    } dp_status_t;

endpackage

// File: hdl/capture_period_rpm_meter.sv
// Top level of the capture-period tachometer: stream ports, register port, controller and datapath.
// One request at a time: overflow, capture, clear-average and refused reads pass from decode
// straight to finish; a frequency read runs one pass of the 42-step shared divider, and an rpm
// read adds a multiply step before that pass; an averaged read takes the rpm read's multiply and
// divider pass, then the ring update and a second divider pass over the ring sum. A stalled
// output holds a request in its finish state. A new request is taken as soon as
// the previous one is done, even while its result still waits in the output register.
// Averaging history resets at once (no clearing pass).
module capture_period_rpm_meter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_value
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [33:0] result_value, zero padded
    output logic        m_tuser,   // [0] data_ready
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cprm_pkg::*;

    ctrl_cmd_t        ctrl;
    dp_status_t       status;
    logic [RES_W-1:0] result;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    cprm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl)
    );

    cprm_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .status     (status),
        .in_cmd     (s_tuser),
        .in_cap     (s_tdata),
        .cfg_wr     (cfg_wr),
        .cfg_sel    (paddr[2]),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (result),
        .out_flag   (m_tuser)
    );

    assign s_tready = ctrl.in_ready;
    assign m_tdata  = {6'd0, result};

endmodule

// File: hdl/cprm_div.sv
// Restoring divider, one quotient bit per cycle.
module cprm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [cprm_pkg::NUM_W-1:0]  num,
    input  logic [cprm_pkg::DEN_W-1:0]  den,
    output logic [cprm_pkg::NUM_W-1:0]  quo,
    output logic                        done
);
    import cprm_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  nq_reg, nq_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, nq_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            nq_next   = num;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next   = {nq_reg[NUM_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quo  = nq_reg;
    assign done = done_reg;

endmodule

// File: hdl/cprm_dp.sv
// Datapath: config registers, capture logic, multiplier, divider, averaging ring, output register.
module cprm_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cprm_pkg::ctrl_cmd_t           ctrl,
    output cprm_pkg::dp_status_t          status,
    input  logic [2:0]                    in_cmd,
    input  logic [cprm_pkg::CAP_W-1:0]    in_cap,
    input  logic                          cfg_wr,
    input  logic                          cfg_sel,
    input  logic [31:0]                   cfg_wdata,
    output logic [31:0]                   cfg_rdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cprm_pkg::RES_W-1:0]    out_result,
    output logic                          out_flag
);
    import cprm_pkg::*;

    logic                enable_reg;
    logic [PPR_W-1:0]    ppr_reg;
    logic [2:0]          cmd_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [CAP_W-1:0]    last_reg, last_next;
    logic [OVF_W-1:0]    ovf_reg, ovf_next;
    logic [PER_W-1:0]    period_reg, period_next;
    logic                flag_reg, flag_next;
    logic [DEN_W-1:0]    prod_reg;
    logic [RES_W-1:0]    result_reg;
    logic [RING_AW-1:0]  idx_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [AVG_DEPTH-1:0] valid_reg;
    logic [RES_W-1:0]    ring_mem [0:AVG_DEPTH-1];
    logic [RES_W-1:0]    rd_reg;
    logic                rd_valid_reg;
    logic                ovalid_reg;
    logic [RES_W-1:0]    ores_reg;
    logic                oflag_reg;
    logic [OVF_W:0]      ovf_inc;
    logic [PER_W-1:0]    per_calc;
    logic [RES_W-1:0]    old_val;
    logic [RING_AW:0]    idx_inc;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [NUM_W-1:0]    div_quo;
    logic                div_done;

    cprm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    always_comb begin
        if (ctrl.div_sel_avg) begin
            div_num = sum_reg;
            div_den = DEN_W'(count_reg);
        end else if (cmd_reg == CMD_READ_FREQ) begin
            div_num = FREQ_NUM;
            div_den = DEN_W'(period_reg);
        end else begin
            div_num = RPM_NUM;
            div_den = prod_reg;
        end
    end

    // Capture state next values
    always_comb begin
        ovf_inc = {1'b0, ovf_reg} + 1'b1;
        if (ovf_reg != '0) begin
            per_calc = {ovf_reg, cap_reg} - PER_W'(last_reg);
        end else if (cap_reg >= last_reg) begin
            per_calc = PER_W'(cap_reg - last_reg);
        end else begin
            per_calc = PER_W'({1'b1, cap_reg} - {1'b0, last_reg});
        end
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        period_next = period_reg;
        flag_next   = flag_reg;
        if (cfg_wr && cfg_sel == REG_ENABLE) begin
            last_next   = '0;
            ovf_next    = '0;
            period_next = '0;
            flag_next   = 1'b0;
        end else if (ctrl.exec_event && enable_reg) begin
            case (cmd_reg)
                CMD_OVERFLOW: begin
                    if (ovf_inc > (OVF_W+1)'(OVERFLOW_LIMIT)) begin
                        last_next = '0;
                        ovf_next  = '0;
                    end else begin
                        ovf_next = ovf_inc[OVF_W-1:0];
                    end
                end
                CMD_CAPTURE: begin
                    if (last_reg != '0) begin
                        period_next = per_calc;
                        flag_next   = 1'b1;
                    end
                    last_next = cap_reg;
                    ovf_next  = '0;
                end
                default: begin
                end
            endcase
        end else if (ctrl.take_quot) begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            ppr_reg    <= '0;
            last_reg   <= '0;
            ovf_reg    <= '0;
            period_reg <= '0;
            flag_reg   <= 1'b0;
        end else begin
            if (cfg_wr && cfg_sel == REG_ENABLE) begin
                enable_reg <= cfg_wdata[0];
            end
            if (cfg_wr && cfg_sel == REG_PPR) begin
                ppr_reg <= cfg_wdata[PPR_W-1:0];
            end
            last_reg   <= last_next;
            ovf_reg    <= ovf_next;
            period_reg <= period_next;
            flag_reg   <= flag_next;
        end
    end

    assign cfg_rdata = (cfg_sel == REG_ENABLE) ? {31'd0, enable_reg} : {16'd0, ppr_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg <= in_cmd;
            cap_reg <= in_cap;
        end
        if (ctrl.mul_en) begin
            prod_reg <= DEN_W'(period_reg) * DEN_W'(ppr_reg);
        end
        if (ctrl.clear_result) begin
            result_reg <= '0;
        end else if (ctrl.take_quot || ctrl.avg_result) begin
            result_reg <= div_quo[RES_W-1:0];
        end
    end

    // Ring: registered read at the write index, valid bits stand in for the zero fill
    assign old_val = rd_valid_reg ? rd_reg : '0;
    assign idx_inc = {1'b0, idx_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        rd_reg <= ring_mem[idx_reg];
        if (ctrl.ring_upd) begin
            ring_mem[idx_reg] <= result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            idx_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end else if (ctrl.exec_event && cmd_reg == CMD_CLEAR_AVG) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            idx_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end else begin
            rd_valid_reg <= valid_reg[idx_reg];
            if (ctrl.ring_upd) begin
                valid_reg[idx_reg] <= 1'b1;
                sum_reg <= sum_reg - SUM_W'(old_val) + SUM_W'(result_reg);
                idx_reg <= (idx_inc >= (RING_AW+1)'(AVG_DEPTH)) ? '0 : idx_inc[RING_AW-1:0];
                if (count_reg < CNT_W'(AVG_DEPTH)) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            ores_reg  <= result_reg;
            oflag_reg <= flag_reg;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_result = ores_reg;
    assign out_flag   = oflag_reg;

    assign status.cmd      = cmd_reg;
    assign status.rpm_ok   = enable_reg && flag_reg && (period_reg != '0) && (ppr_reg != '0);
    assign status.freq_ok  = enable_reg && flag_reg && (period_reg != '0);
    assign status.div_done = div_done;
    assign status.out_free = !ovalid_reg || out_ready;

endmodule

// File: hdl/cprm_ctrl.sv
// Controller state machine sequencing each request through the datapath.
module cprm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  cprm_pkg::dp_status_t  status,
    output cprm_pkg::ctrl_cmd_t   ctrl
);
    import cprm_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if ((status.cmd == CMD_READ_RPM || status.cmd == CMD_READ_AVG) &&
                    status.rpm_ok) begin
                    state_next = ST_MUL;
                end else if (status.cmd == CMD_READ_FREQ && status.freq_ok) begin
                    state_next = ST_DIV1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:   state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_WAIT1;
            ST_WAIT1: begin
                if (status.div_done) begin
                    state_next = (status.cmd == CMD_READ_AVG) ? ST_RING : ST_FINISH;
                end
            end
            ST_RING:  state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_WAIT2;
            ST_WAIT2: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready  = 1'b1;
                ctrl.load_item = in_valid;
            end
            ST_DECODE: begin
                ctrl.clear_result = 1'b1;
                ctrl.exec_event   = 1'b1;
            end
            ST_MUL:   ctrl.mul_en = 1'b1;
            ST_DIV1:  ctrl.div_start = 1'b1;
            ST_WAIT1: ctrl.take_quot = status.div_done;
            ST_RING:  ctrl.ring_upd = 1'b1;
            ST_DIV2: begin
                ctrl.div_start   = 1'b1;
                ctrl.div_sel_avg = 1'b1;
            end
            ST_WAIT2: begin
                ctrl.div_sel_avg = 1'b1;
                ctrl.avg_result  = status.div_done;
            end
            ST_FINISH: ctrl.out_load = status.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_WAIT1 || state_reg == ST_WAIT2))
        else $error("divider finished outside a wait state");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_ring_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ring_upd |-> status.cmd == CMD_READ_AVG)
        else $error("ring updated for a request other than averaged read");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_item |=> !ctrl.in_ready)
        else $error("request accepted while another is in work");

endmodule
